/* src/rtc_pkg.sv */
// Package with the constants, register map and types of the real-time counter.
package rtc_pkg;

  localparam int NUM_COMPARE = 4;
  localparam int COUNT_BITS  = 24;
  localparam int PRESCALE_W  = 12;
  localparam int DATA_W      = 32;
  localparam int INDEX_W     = 5;
  localparam int PULSE_W     = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MASK     = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] TRIG_OVF_VALUE =
      COUNT_MASK & ~(COUNT_BITS'(4'hF));

  localparam int OVF_EN_BIT = 1;
  localparam int CMP_EN_BIT = 16;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  localparam logic [INDEX_W-1:0] IDX_START     = 5'd0;
  localparam logic [INDEX_W-1:0] IDX_STOP      = 5'd1;
  localparam logic [INDEX_W-1:0] IDX_CLEAR     = 5'd2;
  localparam logic [INDEX_W-1:0] IDX_TRIGOVF   = 5'd3;
  localparam logic [INDEX_W-1:0] IDX_CMP_EVT0  = 5'd4;
  localparam logic [INDEX_W-1:0] IDX_OVF_EVT   = 5'd8;
  localparam logic [INDEX_W-1:0] IDX_INTENSET  = 5'd9;
  localparam logic [INDEX_W-1:0] IDX_INTENCLR  = 5'd10;
  localparam logic [INDEX_W-1:0] IDX_EVTENSET  = 5'd11;
  localparam logic [INDEX_W-1:0] IDX_EVTENCLR  = 5'd12;
  localparam logic [INDEX_W-1:0] IDX_COUNTER   = 5'd13;
  localparam logic [INDEX_W-1:0] IDX_CMP_VAL0  = 5'd14;

  typedef struct packed {
    logic               overflow_pulse;
    logic [PULSE_W-1:0] compare_pulse;
    logic               irq;
    logic [DATA_W-1:0]  read_data;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int IN_FIELDS_W = INDEX_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

endpackage

/* src/rtc_counter_compare_overflow_unit.sv */
// Top level of the real-time counter with compare channels and overflow flag.
//
//  Channel     Direction  Contents
//  s_axis      in         tuser: req_type; tdata: reg_index, write_data
//  m_axis      out        tdata: read_data, irq, compare_pulse, overflow_pulse
//  cfg         in         cfg_we_i / cfg_wdata_i: prescale
//
// Each item is processed in the cycle it is accepted and its result is registered
// for m_axis; one item per cycle is sustained while m_axis keeps taking results.
// The result register is backed by a skid register; s_axis_tready drops only
// when both hold results that m_axis has not taken.
// Reset clears all counter state, flags, enables and compare values.
module rtc_counter_compare_overflow_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rtc_pkg::PRESCALE_W-1:0]     cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: reg_index[4:0], write_data[36:5], zero padding.
  input  logic [rtc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: read_data[31:0], irq[32], compare_pulse[36:33],
  // overflow_pulse[37], zero padding.
  output logic [rtc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic [rtc_pkg::PRESCALE_W-1:0] prescale_q;
  logic                           running_q, running_d;
  logic [rtc_pkg::PRESCALE_W-1:0] phase_q, phase_d;
  logic [rtc_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic [rtc_pkg::COUNT_BITS-1:0] cmp_val_q [rtc_pkg::NUM_COMPARE];
  logic [rtc_pkg::COUNT_BITS-1:0] cmp_val_d [rtc_pkg::NUM_COMPARE];
  logic [rtc_pkg::NUM_COMPARE-1:0] cmp_flag_q, cmp_flag_d;
  logic                           ovf_flag_q, ovf_flag_d;
  logic [rtc_pkg::DATA_W-1:0]     irq_en_q, irq_en_d;
  logic [rtc_pkg::DATA_W-1:0]     evt_en_q, evt_en_d;

  logic                           out_valid_q, out_valid_d;
  rtc_pkg::result_t               out_q, out_d;
  logic                           skid_valid_q, skid_valid_d;
  rtc_pkg::result_t               skid_q, skid_d;

  rtc_pkg::req_e                  req;
  logic [rtc_pkg::INDEX_W-1:0]    idx;
  logic [rtc_pkg::DATA_W-1:0]     wdata;
  logic                           data_nz;
  logic [rtc_pkg::COUNT_BITS-1:0] count_inc;
  rtc_pkg::result_t               res;
  logic                           push, pop;

  assign req       = rtc_pkg::req_e'(s_axis_tuser);
  assign idx       = s_axis_tdata[rtc_pkg::INDEX_W-1:0];
  assign wdata     = s_axis_tdata[rtc_pkg::IN_FIELDS_W-1:rtc_pkg::INDEX_W];
  assign data_nz   = |wdata;
  assign count_inc = count_q + rtc_pkg::COUNT_BITS'(1);

  assign s_axis_tready = !skid_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  always_comb begin
    running_d  = running_q;
    phase_d    = phase_q;
    count_d    = count_q;
    cmp_val_d  = cmp_val_q;
    cmp_flag_d = cmp_flag_q;
    ovf_flag_d = ovf_flag_q;
    irq_en_d   = irq_en_q;
    evt_en_d   = evt_en_q;
    res        = '0;

    if (push) begin
      case (req)
        rtc_pkg::REQ_TICK: begin
          if (running_q) begin
            if (phase_q < prescale_q) begin
              phase_d = phase_q + rtc_pkg::PRESCALE_W'(1);
            end else begin
              phase_d = '0;
              count_d = count_inc;
              for (int n = 0; n < rtc_pkg::NUM_COMPARE; n++) begin
                if (count_inc == cmp_val_q[n]) begin
                  cmp_flag_d[n] = 1'b1;
                  res.compare_pulse[n] = evt_en_q[rtc_pkg::CMP_EN_BIT + n];
                end
              end
              if (count_inc == '0) begin
                ovf_flag_d = 1'b1;
                res.overflow_pulse = evt_en_q[rtc_pkg::OVF_EN_BIT];
              end
            end
          end
        end
        rtc_pkg::REQ_WRITE: begin
          case (idx)
            rtc_pkg::IDX_START: begin
              if (data_nz && !running_q) begin
                running_d = 1'b1;
                phase_d   = '0;
              end
            end
            rtc_pkg::IDX_STOP: begin
              if (data_nz) begin
                running_d = 1'b0;
              end
            end
            rtc_pkg::IDX_CLEAR: begin
              if (data_nz) begin
                count_d = '0;
                phase_d = '0;
              end
            end
            rtc_pkg::IDX_TRIGOVF: begin
              if (data_nz) begin
                count_d = rtc_pkg::TRIG_OVF_VALUE;
                phase_d = '0;
              end
            end
            rtc_pkg::IDX_OVF_EVT:  ovf_flag_d = data_nz;
            rtc_pkg::IDX_INTENSET: irq_en_d = irq_en_q | wdata;
            rtc_pkg::IDX_INTENCLR: irq_en_d = irq_en_q & ~wdata;
            rtc_pkg::IDX_EVTENSET: evt_en_d = evt_en_q | wdata;
            rtc_pkg::IDX_EVTENCLR: evt_en_d = evt_en_q & ~wdata;
            default: begin
              for (int n = 0; n < rtc_pkg::NUM_COMPARE; n++) begin
                if (idx == rtc_pkg::IDX_CMP_EVT0 + rtc_pkg::INDEX_W'(n)) begin
                  cmp_flag_d[n] = data_nz;
                end
                if (idx == rtc_pkg::IDX_CMP_VAL0 + rtc_pkg::INDEX_W'(n)) begin
                  cmp_val_d[n] = wdata[rtc_pkg::COUNT_BITS-1:0];
                end
              end
            end
          endcase
        end
        rtc_pkg::REQ_READ: begin
          case (idx)
            rtc_pkg::IDX_OVF_EVT:  res.read_data = rtc_pkg::DATA_W'(ovf_flag_q);
            rtc_pkg::IDX_INTENSET,
            rtc_pkg::IDX_INTENCLR: res.read_data = irq_en_q;
            rtc_pkg::IDX_EVTENSET,
            rtc_pkg::IDX_EVTENCLR: res.read_data = evt_en_q;
            rtc_pkg::IDX_COUNTER:  res.read_data = rtc_pkg::DATA_W'(count_q);
            default: begin
              for (int n = 0; n < rtc_pkg::NUM_COMPARE; n++) begin
                if (idx == rtc_pkg::IDX_CMP_EVT0 + rtc_pkg::INDEX_W'(n)) begin
                  res.read_data = rtc_pkg::DATA_W'(cmp_flag_q[n]);
                end
                if (idx == rtc_pkg::IDX_CMP_VAL0 + rtc_pkg::INDEX_W'(n)) begin
                  res.read_data = rtc_pkg::DATA_W'(cmp_val_q[n]);
                end
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    res.irq = ovf_flag_d && irq_en_d[rtc_pkg::OVF_EN_BIT];
    for (int n = 0; n < rtc_pkg::NUM_COMPARE; n++) begin
      if (cmp_flag_d[n] && irq_en_d[rtc_pkg::CMP_EN_BIT + n]) begin
        res.irq = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_d       = res;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q   <= '0;
      running_q    <= 1'b0;
      phase_q      <= '0;
      count_q      <= '0;
      cmp_val_q    <= '{default: '0};
      cmp_flag_q   <= '0;
      ovf_flag_q   <= 1'b0;
      irq_en_q     <= '0;
      evt_en_q     <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prescale_q <= cfg_wdata_i;
      end
      running_q    <= running_d;
      phase_q      <= phase_d;
      count_q      <= count_d;
      cmp_val_q    <= cmp_val_d;
      cmp_flag_q   <= cmp_flag_d;
      ovf_flag_q   <= ovf_flag_d;
      irq_en_q     <= irq_en_d;
      evt_en_q     <= evt_en_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rtc_pkg::OUT_TDATA_W'(out_q);

endmodule

/* tb/sv/rtc_counter_compare_overflow_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the real-time counter: directed table, then random items.
module rtc_counter_compare_overflow_unit_tb;
  import rtc_pkg::*;

  localparam logic [1:0]         REQ_UNKNOWN = 2'd3;
  localparam logic [INDEX_W-1:0] IDX_NONE_LO = 5'd18;
  localparam logic [INDEX_W-1:0] IDX_NONE_HI = 5'd31;
  localparam int NUM_DIR     = 30;
  localparam int NUM_PHASES  = 6;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;
  localparam int CH_W        = $clog2(NUM_COMPARE);

  typedef struct packed {
    logic [1:0]         req;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  data;
    logic [4:0]         reps;
    logic               chk;
    logic [DATA_W-1:0]  x_rd;
    logic               x_irq;
  } stim_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [PRESCALE_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predicted state of the counter.
  logic [PRESCALE_W-1:0]  pr_prescale = '0;
  logic                   pr_running  = 1'b0;
  logic [PRESCALE_W-1:0]  pr_phase    = '0;
  logic [COUNT_BITS-1:0]  pr_count    = '0;
  logic [COUNT_BITS-1:0]  pr_cmp_val [NUM_COMPARE] = '{default: '0};
  logic [NUM_COMPARE-1:0] pr_cmp_flag = '0;
  logic                   pr_ovf_flag = 1'b0;
  logic [DATA_W-1:0]      pr_int_en   = '0;
  logic [DATA_W-1:0]      pr_evt_en   = '0;

  result_t   pending_results [$];
  stim_row_t dir_rows [NUM_DIR];
  int        fail_cnt     = 0;
  int        stall_cycles = 0;
  int        hold_req     = 0;
  int        hold_seen    = 0;
  int        hold_cnt     = 0;
  logic      quiet        = 1'b0;

  rtc_counter_compare_overflow_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t predict_rtc_result(input logic [1:0] req,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [DATA_W-1:0] data);
    result_t         r;
    int              n;
    logic [CH_W-1:0] ch;
    r = '0;
    case (req)
      REQ_TICK: begin
        if (pr_running) begin
          if (pr_phase < pr_prescale) begin
            pr_phase = pr_phase + 1'b1;
          end else begin
            pr_phase = '0;
            pr_count = pr_count + 1'b1;
            for (n = 0; n < NUM_COMPARE; n++) begin
              if (pr_count == pr_cmp_val[n]) begin
                pr_cmp_flag[n] = 1'b1;
                if (pr_evt_en[CMP_EN_BIT + n]) r.compare_pulse[n] = 1'b1;
              end
            end
            if (pr_count == '0) begin
              pr_ovf_flag = 1'b1;
              r.overflow_pulse = pr_evt_en[OVF_EN_BIT];
            end
          end
        end
      end
      REQ_WRITE: begin
        case (idx)
          IDX_START: begin
            if (data != 0 && !pr_running) begin
              pr_running = 1'b1;
              pr_phase   = '0;
            end
          end
          IDX_STOP: begin
            if (data != 0) pr_running = 1'b0;
          end
          IDX_CLEAR: begin
            if (data != 0) begin
              pr_count = '0;
              pr_phase = '0;
            end
          end
          IDX_TRIGOVF: begin
            if (data != 0) begin
              pr_count = TRIG_OVF_VALUE;
              pr_phase = '0;
            end
          end
          IDX_OVF_EVT:  pr_ovf_flag = (data != 0);
          IDX_INTENSET: pr_int_en = pr_int_en | data;
          IDX_INTENCLR: pr_int_en = pr_int_en & ~data;
          IDX_EVTENSET: pr_evt_en = pr_evt_en | data;
          IDX_EVTENCLR: pr_evt_en = pr_evt_en & ~data;
          default: begin
            if (idx >= IDX_CMP_EVT0 && idx < IDX_CMP_EVT0 + NUM_COMPARE) begin
              ch = CH_W'(idx - IDX_CMP_EVT0);
              pr_cmp_flag[ch] = (data != 0);
            end else if (idx >= IDX_CMP_VAL0 && idx < IDX_CMP_VAL0 + NUM_COMPARE) begin
              ch = CH_W'(idx - IDX_CMP_VAL0);
              pr_cmp_val[ch] = data[COUNT_BITS-1:0];
            end
          end
        endcase
      end
      REQ_READ: begin
        case (idx)
          IDX_OVF_EVT:                r.read_data = DATA_W'(pr_ovf_flag);
          IDX_INTENSET, IDX_INTENCLR: r.read_data = pr_int_en;
          IDX_EVTENSET, IDX_EVTENCLR: r.read_data = pr_evt_en;
          IDX_COUNTER:                r.read_data = DATA_W'(pr_count);
          default: begin
            if (idx >= IDX_CMP_EVT0 && idx < IDX_CMP_EVT0 + NUM_COMPARE) begin
              ch = CH_W'(idx - IDX_CMP_EVT0);
              r.read_data = DATA_W'(pr_cmp_flag[ch]);
            end else if (idx >= IDX_CMP_VAL0 && idx < IDX_CMP_VAL0 + NUM_COMPARE) begin
              ch = CH_W'(idx - IDX_CMP_VAL0);
              r.read_data = DATA_W'(pr_cmp_val[ch]);
            end
          end
        endcase
      end
      default: ;
    endcase
    r.irq = pr_ovf_flag & pr_int_en[OVF_EN_BIT];
    for (n = 0; n < NUM_COMPARE; n++)
      r.irq = r.irq | (pr_cmp_flag[n] & pr_int_en[CMP_EN_BIT + n]);
    return r;
  endfunction

  // Mostly well-formed traffic: start, compare values just ahead of the count, ticks.
  task automatic pick_random_item(output logic [1:0] req, output logic [INDEX_W-1:0] idx,
                                  output logic [DATA_W-1:0] data);
    int sel;
    sel  = $urandom_range(0, 99);
    data = $urandom();
    idx  = INDEX_W'($urandom_range(0, 31));
    if (sel < 50) begin
      req = REQ_TICK;
    end else if (sel < 85) begin
      req = REQ_WRITE;
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        if (sel < 12) idx = IDX_START;
        else if (sel < 17) idx = IDX_STOP;
        else if (sel < 22) idx = IDX_CLEAR;
        else idx = IDX_TRIGOVF;
        if ($urandom_range(0, 7) == 0) data = '0;
      end else if (sel < 48) begin
        idx = IDX_CMP_VAL0 + INDEX_W'($urandom_range(0, NUM_COMPARE - 1));
        if ($urandom_range(0, 9) < 7)
          data[COUNT_BITS-1:0] = pr_count + COUNT_BITS'($urandom_range(1, 16));
      end else if (sel < 60) begin
        idx = IDX_CMP_EVT0 + INDEX_W'($urandom_range(0, NUM_COMPARE));
        if ($urandom_range(0, 1) == 0) data = '0;
      end else if (sel < 85) begin
        idx = IDX_INTENSET + INDEX_W'($urandom_range(0, 3));
      end
    end else if (sel < 97) begin
      req = REQ_READ;
      if ($urandom_range(0, 3) != 0) idx = INDEX_W'($urandom_range(0, 17));
    end else begin
      req = REQ_UNKNOWN;
    end
  endtask

  task automatic send_item(input logic [1:0] req, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] data, input logic chk,
                           input result_t fixed_res);
    result_t want;
    while (!quiet && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= IN_TDATA_W'({data, idx});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_rtc_result(req, idx, data);
    pending_results.push_back(chk ? fixed_res : want);
  endtask

  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (hold_req != hold_seen) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= hold_req;
      hold_cnt      <= HOLD_CYCLES;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RESULT_W-1:0];
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("ERROR: result without a pending item: rd=%h irq=%b cmp=%b ovf=%b",
                   got.read_data, got.irq, got.compare_pulse, got.overflow_pulse);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data || got.irq !== want.irq ||
            got.compare_pulse !== want.compare_pulse ||
            got.overflow_pulse !== want.overflow_pulse) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("ERROR: expected rd=%h irq=%b cmp=%b ovf=%b, got rd=%h irq=%b cmp=%b ovf=%b",
                     want.read_data, want.irq, want.compare_pulse, want.overflow_pulse,
                     got.read_data, got.irq, got.compare_pulse, got.overflow_pulse);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("rtc_counter_compare_overflow_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int                    i;
    int                    j;
    int                    ph;
    int                    k;
    int                    phase_len [NUM_PHASES];
    logic [PRESCALE_W-1:0] phase_prescale [NUM_PHASES];
    logic [PRESCALE_W-1:0] ps;
    logic [1:0]            req;
    logic [INDEX_W-1:0]    idx;
    logic [DATA_W-1:0]     data;
    result_t               fixed_res;

    phase_len      = '{300, 150, 250, 200, 200, 200};
    phase_prescale = '{12'd0, 12'hFFF, 12'd1, 12'd3, 12'd0, 12'd0};
    dir_rows = '{
      '{REQ_READ,    IDX_COUNTER,        32'h0,         5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_READ,    IDX_OVF_EVT,        32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_TICK,    IDX_NONE_HI,        32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_COUNTER,        32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_CMP_VAL0,       32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_READ,    IDX_CMP_VAL0,       32'h0,         5'd1, 1'b1, 32'h00FF_FFFF, 1'b0},
      '{REQ_WRITE,   IDX_CMP_VAL0 + 5'd1, 32'h2,        5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_EVTENSET,       32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_INTENSET,       32'h0002_0002, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_STOP,           32'h1,         5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_START,          32'h0,         5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_TICK,    IDX_START,          32'h0,         5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_START,          32'h8000_0000, 5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_TICK,    IDX_CLEAR,          32'h0,         5'd2, 1'b0, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_START,          32'h1,         5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_READ,    IDX_CMP_EVT0 + 5'd1, 32'h0,        5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_CMP_EVT0 + 5'd1, 32'h0,        5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_TRIGOVF,        32'h1,         5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_READ,    IDX_COUNTER,        32'h0,         5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_OVF_EVT,        32'h10,        5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_READ,    IDX_OVF_EVT,        32'h0,         5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_INTENCLR,       32'hFFFF_FFFF, 5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_EVTENCLR,       32'h0000_0002, 5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_READ,    IDX_EVTENSET,       32'h0,         5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_CLEAR,          32'h1,         5'd1, 1'b0, 32'h0,         1'b0},
      '{REQ_READ,    IDX_START,          32'h0,         5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_READ,    IDX_NONE_HI,        32'h0,         5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_WRITE,   IDX_NONE_LO,        32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_UNKNOWN, IDX_COUNTER,        32'hFFFF_FFFF, 5'd1, 1'b1, 32'h0,         1'b0},
      '{REQ_READ,    IDX_COUNTER,        32'h0,         5'd1, 1'b0, 32'h0,         1'b0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < NUM_DIR; i++) begin
      fixed_res           = '0;
      fixed_res.read_data = dir_rows[i].x_rd;
      fixed_res.irq       = dir_rows[i].x_irq;
      for (j = 0; j < dir_rows[i].reps; j++)
        send_item(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].data, dir_rows[i].chk,
                  fixed_res);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      ps = (ph == 4) ? PRESCALE_W'($urandom_range(0, 4095)) : phase_prescale[ph];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= ps;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      pr_prescale = ps;
      quiet       <= (ph == 3);
      for (k = 0; k < phase_len[ph]; k++) begin
        pick_random_item(req, idx, data);
        send_item(req, idx, data, 1'b0, '0);
        if (ph == 0 && k == 100) hold_req <= hold_req + 1;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("rtc_counter_compare_overflow_unit test passed");
    end else begin
      $display("rtc_counter_compare_overflow_unit test failed");
    end
    $finish;
  end

endmodule
